// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds at the same edge.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons holds at the following edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rftt_pkg.sv =====
// ----------------------------------------------------------------------------
// rftt_pkg
// Types and constants shared by the range frame translation table.
// ----------------------------------------------------------------------------
package rftt_pkg;

  // Number of stored range mappings.
  localparam int ENTRIES = 16;
  // Bits needed to index one entry.
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  // Bits of a counter that can also hold ENTRIES itself.
  localparam int CNT_W = $clog2(ENTRIES + 1);

  localparam int FRAME_W = 32;
  localparam int LEN_W   = 21;

  localparam logic [FRAME_W-1:0] INVALID_FRAME = '1;

  typedef enum logic [1:0] {
    ACT_SET      = 2'd0,
    ACT_G2M      = 2'd1,
    ACT_M2G      = 2'd2,
    ACT_M2LOCAL  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_DUP      = 2'd2,
    ST_CONFLICT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_t;

  // One input transfer.
  typedef struct packed {
    logic [1:0]         action;
    logic [FRAME_W-1:0] guest_frame;
    logic [FRAME_W-1:0] machine_frame;
    logic [LEN_W-1:0]   page_count;
  } in_item_t;

  // One result transfer.
  typedef struct packed {
    logic [FRAME_W-1:0] frame_out;
    logic [1:0]         status;
  } out_item_t;

  // One stored range mapping as held in the entry memory.
  typedef struct packed {
    logic [FRAME_W-1:0] guest_start;
    logic [FRAME_W-1:0] machine_start;
    logic [LEN_W-1:0]   range_length;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== hw/rtl/rftt_ram.sv =====
// ----------------------------------------------------------------------------
// rftt_ram
// Simple dual-port synchronous RAM: one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
module rftt_ram #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/range_frame_translation_table_unit.sv =====
// ----------------------------------------------------------------------------
// range_frame_translation_table_unit
// Table of range mappings between guest and machine frames, with set,
// remove and three translation lookups.
// ----------------------------------------------------------------------------
// A transfer is accepted only in the idle state, so a new transfer waits
// until the previous result has been loaded into the output register. The
// entry memory is read one entry per cycle while every stored range is
// compared against the frame. A decide state follows; once the output
// register is free, it decides, writes the entry memory back and loads
// the output register. Valid bits live in flip-flops and are cleared by
// reset, so no clearing pass is needed. The output register holds a
// finished result while the next item is scanned.
module range_frame_translation_table_unit
  import rftt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  `include "assert_macros.svh"

  state_t             state_r, state_nxt;
  logic               init_dom_r;
  in_item_t           req_r;
  logic [ENTRIES-1:0] valid_r;

  logic [CNT_W-1:0]   issue_r;
  logic               cmp_vld_r;
  logic [IDX_W-1:0]   cmp_idx_r;

  logic               hit_found_r;
  logic [IDX_W-1:0]   hit_idx_r;
  logic [FRAME_W-1:0] hit_gs_r;
  logic [FRAME_W-1:0] hit_ms_r;
  logic               free_found_r;
  logic [IDX_W-1:0]   free_idx_r;
  logic               dup_r;

  logic               out_valid_r;
  out_item_t          out_data_r;

  logic               rd_en;
  entry_t             rd_entry;
  logic               wr_en;
  entry_t             wr_entry;
  logic               clr_en;
  logic               decide_go;
  logic               scan_last;
  logic               in_xfer;
  out_item_t          resp;

  logic [FRAME_W-1:0] key_frame;
  logic [FRAME_W-1:0] key_start;
  logic [FRAME_W:0]   key_end;
  logic               cur_valid;
  logic               cur_match;
  logic               cur_dup;
  logic               guest_side;

  assign in_xfer = in_valid && in_ready;

  // Entry memory: start frames and length of each range.
  rftt_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (ENTRY_W)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (free_idx_r),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (issue_r[IDX_W-1:0]),
    .rd_data (rd_entry)
  );

  // Set and guest-to-machine match on the guest side, the others on the
  // machine side.
  assign guest_side = (req_r.action == ACT_SET) || (req_r.action == ACT_G2M);

  // Range compare for the entry whose read data has just arrived.
  always_comb begin
    key_frame = guest_side ? req_r.guest_frame : req_r.machine_frame;
    key_start = guest_side ? rd_entry.guest_start : rd_entry.machine_start;
    key_end   = {1'b0, key_start} + {{(FRAME_W + 1 - LEN_W){1'b0}}, rd_entry.range_length};
    cur_valid = valid_r[cmp_idx_r];
    cur_match = cur_valid && (key_frame >= key_start) && ({1'b0, key_frame} < key_end);
    cur_dup   = cur_valid && ((rd_entry.guest_start == req_r.guest_frame) ||
                              (rd_entry.machine_start == req_r.machine_frame));
  end

  assign scan_last = cmp_vld_r && (cmp_idx_r == IDX_W'(ENTRIES - 1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_xfer) state_nxt = S_SCAN;
      S_SCAN:   if (scan_last) state_nxt = S_DECIDE;
      S_DECIDE: if (decide_go) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // FSM outputs.
  always_comb begin
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    decide_go = 1'b0;
    unique case (state_r)
      S_IDLE:   in_ready  = 1'b1;
      S_SCAN:   rd_en     = (issue_r < CNT_W'(ENTRIES));
      S_DECIDE: decide_go = !out_valid_r || out_ready;
      default:  in_ready  = 1'b0;
    endcase
  end

  // Decision: result, insert and remove.
  always_comb begin
    resp.frame_out = '0;
    resp.status    = ST_OK;
    wr_en          = 1'b0;
    clr_en         = 1'b0;
    wr_entry.guest_start   = req_r.guest_frame;
    wr_entry.machine_start = req_r.machine_frame;
    wr_entry.range_length  = req_r.page_count;
    unique case (action_e'(req_r.action))
      ACT_SET: begin
        priority if (hit_found_r) begin
          if ((req_r.machine_frame != INVALID_FRAME) &&
              (req_r.machine_frame != req_r.guest_frame)) begin
            resp.status = ST_CONFLICT;
          end else begin
            clr_en = decide_go;
          end
        end else if (req_r.machine_frame == INVALID_FRAME) begin
          resp.status = ST_OK;
        end else if (!free_found_r) begin
          resp.status = ST_FULL;
        end else if (dup_r) begin
          resp.status = ST_DUP;
        end else begin
          wr_en = decide_go;
        end
      end
      ACT_G2M: begin
        if (hit_found_r) begin
          resp.frame_out = hit_ms_r + (req_r.guest_frame - hit_gs_r);
        end else begin
          resp.frame_out = init_dom_r ? req_r.guest_frame : INVALID_FRAME;
        end
      end
      ACT_M2G: begin
        if (hit_found_r) begin
          resp.frame_out = hit_gs_r + (req_r.machine_frame - hit_ms_r);
        end else begin
          resp.frame_out = init_dom_r ? req_r.machine_frame : INVALID_FRAME;
        end
      end
      ACT_M2LOCAL: begin
        resp.frame_out = (!init_dom_r || hit_found_r) ? INVALID_FRAME : req_r.machine_frame;
      end
      default: resp.frame_out = '0;
    endcase
  end

  // Control state, scan bookkeeping and valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      init_dom_r  <= 1'b0;
      valid_r     <= '0;
      issue_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        init_dom_r <= cfg_wr_data;
      end
      if (in_xfer) begin
        issue_r   <= '0;
        cmp_vld_r <= 1'b0;
      end else if (state_r == S_SCAN) begin
        cmp_vld_r <= rd_en;
        if (rd_en) begin
          issue_r <= issue_r + CNT_W'(1);
        end
      end else begin
        cmp_vld_r <= 1'b0;
      end
      if (clr_en) begin
        valid_r[hit_idx_r] <= 1'b0;
      end
      if (wr_en) begin
        valid_r[free_idx_r] <= 1'b1;
      end
      if (decide_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request capture and per-scan trackers; the lowest matching entry wins.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r        <= in_data;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      dup_r        <= 1'b0;
    end else if (cmp_vld_r) begin
      if (cur_match && !hit_found_r) begin
        hit_found_r <= 1'b1;
        hit_idx_r   <= cmp_idx_r;
        hit_gs_r    <= rd_entry.guest_start;
        hit_ms_r    <= rd_entry.machine_start;
      end
      if (!cur_valid && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= cmp_idx_r;
      end
      if (cur_dup) begin
        dup_r <= 1'b1;
      end
    end
    if (rd_en) begin
      cmp_idx_r <= issue_r[IDX_W-1:0];
    end
    if (decide_go) begin
      out_data_r <= resp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks on the sequencer and the entry bookkeeping.
  `ASSERT_NEXT(a_accept_starts_scan, in_xfer, state_r == S_SCAN, "accept did not start a scan")
  `ASSERT_SAME(a_decide_after_scan, state_r == S_DECIDE, (issue_r == CNT_W'(ENTRIES)) && !cmp_vld_r, "decide before all entries were compared")
  `ASSERT_SAME(a_insert_free_slot, wr_en, !valid_r[free_idx_r], "insert into an occupied entry")
  `ASSERT_SAME(a_remove_valid_slot, clr_en, valid_r[hit_idx_r], "remove of an empty entry")

endmodule

// ===== dv/rftt_translation_checker.sv =====
// ----------------------------------------------------------------------------
// rftt_translation_checker
// Watches the configuration port and both channels of the range frame
// translation table. It keeps its own copy of the range table and of the
// initial-domain bit, predicts the result of every accepted input transfer
// and compares each accepted result transfer field by field with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module rftt_translation_checker
  import rftt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        mismatch_count,
  output int        results_pending
);

  // Shadow copy of the register and of the range table.
  logic               self_map;
  logic               slot_used    [ENTRIES];
  logic [FRAME_W-1:0] slot_guest   [ENTRIES];
  logic [FRAME_W-1:0] slot_machine [ENTRIES];
  logic [LEN_W-1:0]   slot_len     [ENTRIES];

  // Predicted results, oldest first.
  out_item_t results_due[$];

  // A frame lies in a span when base <= f < base + len, with the end taken
  // one bit wider so that a span never wraps past the top frame.
  function automatic bit frame_in_span(input logic [FRAME_W-1:0] base,
                                       input logic [LEN_W-1:0]   len,
                                       input logic [FRAME_W-1:0] f);
    logic [FRAME_W:0] stop;
    stop = (FRAME_W + 1)'(base) + (FRAME_W + 1)'(len);
    return (f >= base) && ((FRAME_W + 1)'(f) < stop);
  endfunction

  // Lowest-numbered valid entry whose guest or machine span holds the frame.
  function automatic int first_slot_holding(input bit by_machine,
                                            input logic [FRAME_W-1:0] f);
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_used[i] &&
          frame_in_span(by_machine ? slot_machine[i] : slot_guest[i], slot_len[i], f))
        return i;
    end
    return -1;
  endfunction

  // Set action: remove, ignore, insert, or report a conflict, a full table or a duplicate.
  function automatic status_e apply_set(input logic [FRAME_W-1:0] g,
                                        input logic [FRAME_W-1:0] m,
                                        input logic [LEN_W-1:0]   len);
    int hit;
    int free_slot;
    hit = first_slot_holding(1'b0, g);
    if (hit >= 0) begin
      if (m != INVALID_FRAME && m != g)
        return ST_CONFLICT;
      slot_used[hit] = 1'b0;
      return ST_OK;
    end
    if (m == INVALID_FRAME)
      return ST_OK;
    free_slot = -1;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!slot_used[i])
        free_slot = i;
    end
    if (free_slot < 0)
      return ST_FULL;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_used[i] && (slot_guest[i] == g || slot_machine[i] == m))
        return ST_DUP;
    end
    slot_used[free_slot]    = 1'b1;
    slot_guest[free_slot]   = g;
    slot_machine[free_slot] = m;
    slot_len[free_slot]     = len;
    return ST_OK;
  endfunction

  // Expected result of one input transfer; a set also updates the table.
  function automatic out_item_t predict_result(input in_item_t it);
    out_item_t res;
    int        hit;
    res.frame_out = '0;
    res.status    = ST_OK;
    case (action_e'(it.action))
      ACT_SET: begin
        res.status = apply_set(it.guest_frame, it.machine_frame, it.page_count);
      end
      ACT_G2M: begin
        hit = first_slot_holding(1'b0, it.guest_frame);
        if (hit >= 0)
          res.frame_out = slot_machine[hit] + (it.guest_frame - slot_guest[hit]);
        else
          res.frame_out = self_map ? it.guest_frame : INVALID_FRAME;
      end
      ACT_M2G: begin
        hit = first_slot_holding(1'b1, it.machine_frame);
        if (hit >= 0)
          res.frame_out = slot_guest[hit] + (it.machine_frame - slot_machine[hit]);
        else
          res.frame_out = self_map ? it.machine_frame : INVALID_FRAME;
      end
      default: begin
        if (!self_map || first_slot_holding(1'b1, it.machine_frame) >= 0)
          res.frame_out = INVALID_FRAME;
        else
          res.frame_out = it.machine_frame;
      end
    endcase
    return res;
  endfunction

  // Everything is sampled at the rising edge, so inputs and outputs are
  // seen with the values they held just before it.
  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      self_map = 1'b0;
      for (int i = 0; i < ENTRIES; i++)
        slot_used[i] = 1'b0;
      results_due.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_wr_en)
        self_map = cfg_wr_data;

      // Compare a result transfer with the oldest prediction.
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: result with none expected: actual frame_out %h status %0d",
                   $time, out_data.frame_out, out_data.status);
          mismatch_count++;
        end else begin
          want = results_due.pop_front();
          if (out_data.frame_out !== want.frame_out) begin
            $display("%0t: frame_out mismatch: expected %h actual %h",
                     $time, want.frame_out, out_data.frame_out);
            mismatch_count++;
          end
          if (out_data.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, out_data.status);
            mismatch_count++;
          end
        end
      end

      // Predict the result of an input transfer.
      if (in_valid && in_ready)
        results_due.push_back(predict_result(in_data));
    end
    results_pending = results_due.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the range frame translation table. A directed
// sequence covers empty-table fallbacks, inserts, conflicts, duplicates,
// zero and oversize lengths, wrap of translations, overlapping ranges and
// both kinds of remove. Random phases then mix well-formed set, remove and
// lookup transfers built from recently stored ranges with pure noise, under
// both settings of the initial-domain register and with random idling on
// both channels. The checker beside the block does all prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import rftt_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int PHASE_ITEMS   = 300;
  localparam int POOL_DEPTH    = 64;
  localparam logic [LEN_W-1:0] MAX_COUNT = 21'd1048576;

  logic      clk         = 1'b0;
  logic      rst_n       = 1'b0;
  logic      cfg_wr_en   = 1'b0;
  logic      cfg_wr_data = 1'b0;
  logic      in_valid    = 1'b0;
  logic      in_ready;
  in_item_t  in_data     = '0;
  logic      out_valid;
  logic      out_ready   = 1'b0;
  out_item_t out_data;
  logic      idle_on     = 1'b1;
  int        cycle_count = 0;
  int        mismatch_count;
  int        results_pending;

  // Ranges offered by recent set transfers, reused for lookups and removes.
  logic [FRAME_W-1:0] seen_guest   [POOL_DEPTH];
  logic [FRAME_W-1:0] seen_machine [POOL_DEPTH];
  logic [LEN_W-1:0]   seen_len     [POOL_DEPTH];
  int                 seen_count = 0;
  int                 seen_next  = 0;

  range_frame_translation_table_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  rftt_translation_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  always #5 clk = ~clk;

  // The result side stalls at random, with odds of 16 in 100, while idling is on.
  always @(posedge clk) begin
    out_ready <= !idle_on || ($urandom_range(0, 99) >= 16);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Mostly short ranges, sometimes any 21-bit count, sometimes an edge value.
  function automatic logic [LEN_W-1:0] pick_count();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 85)
      return LEN_W'($urandom_range(1, 256));
    if (roll < 95)
      return LEN_W'($urandom());
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return LEN_W'(1);
      2:       return MAX_COUNT;
      default: return '1;
    endcase
  endfunction

  // A fresh frame, now and then close to the top of the frame space.
  function automatic logic [FRAME_W-1:0] pick_frame();
    if ($urandom_range(0, 9) == 0)
      return FRAME_W'(32'hFFFF_FF00 | $urandom_range(0, 255));
    return FRAME_W'($urandom());
  endfunction

  // Offset inside a range, occasionally the first frame past its end.
  function automatic logic [FRAME_W-1:0] pick_offset(input logic [LEN_W-1:0] len);
    if (len == 0 || $urandom_range(0, 15) == 0)
      return FRAME_W'(len);
    return FRAME_W'($urandom_range(0, len - 1));
  endfunction

  function automatic void remember_range(input in_item_t it);
    seen_guest[seen_next]   = it.guest_frame;
    seen_machine[seen_next] = it.machine_frame;
    seen_len[seen_next]     = it.page_count;
    seen_next = (seen_next + 1) % POOL_DEPTH;
    if (seen_count < POOL_DEPTH)
      seen_count++;
  endfunction

  // One random transfer: mostly well-formed against known ranges, some noise.
  function automatic in_item_t next_random_item();
    in_item_t it;
    int       roll;
    int       k;
    it.action        = ACT_SET;
    it.guest_frame   = $urandom();
    it.machine_frame = $urandom();
    it.page_count    = pick_count();
    roll = $urandom_range(0, 99);
    k = (seen_count == 0) ? 0 : $urandom_range(0, seen_count - 1);
    if (seen_count == 0 || roll < 30) begin
      // Insert of a fresh range.
      it.guest_frame   = pick_frame();
      it.machine_frame = pick_frame();
      remember_range(it);
    end else if (roll < 45) begin
      // Remove with the invalid marker.
      it.guest_frame   = seen_guest[k] + pick_offset(seen_len[k]);
      it.machine_frame = INVALID_FRAME;
    end else if (roll < 50) begin
      // Remove that names the guest frame as its own machine frame.
      it.guest_frame   = seen_guest[k] + pick_offset(seen_len[k]);
      it.machine_frame = it.guest_frame;
    end else if (roll < 55) begin
      // Set on a mapped frame with some other machine frame: a conflict.
      it.guest_frame = seen_guest[k] + pick_offset(seen_len[k]);
    end else if (roll < 60) begin
      // Reuse one start frame to provoke the duplicate check.
      if ($urandom_range(0, 1) == 1)
        it.machine_frame = seen_machine[k];
      else
        it.guest_frame = seen_guest[k];
      remember_range(it);
    end else if (roll < 75) begin
      it.action      = ACT_G2M;
      it.guest_frame = seen_guest[k] + pick_offset(seen_len[k]);
    end else if (roll < 87) begin
      it.action        = ACT_M2G;
      it.machine_frame = seen_machine[k] + pick_offset(seen_len[k]);
    end else if (roll < 95) begin
      it.action        = ACT_M2LOCAL;
      it.machine_frame = ($urandom_range(0, 1) == 1) ?
                         seen_machine[k] + pick_offset(seen_len[k]) : pick_frame();
    end else begin
      // Noise: every field uniformly random.
      it.action     = 2'($urandom_range(0, 3));
      it.page_count = LEN_W'($urandom());
    end
    return it;
  endfunction

  // Present one input transfer and return at the edge that accepts it.
  // Valid is left high so that a following transfer can start at once.
  task automatic send_item(input in_item_t item);
    if (idle_on && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic send_fields(input action_e act, input logic [FRAME_W-1:0] g,
                             input logic [FRAME_W-1:0] m, input logic [LEN_W-1:0] len);
    in_item_t it;
    it.action        = act;
    it.guest_frame   = g;
    it.machine_frame = m;
    it.page_count    = len;
    send_item(it);
  endtask

  // Let every predicted result arrive, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_pending != 0);
    repeat (ENTRIES + 6) @(posedge clk);
  endtask

  task automatic write_domain(input logic value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic run_random(input int count);
    for (int n = 0; n < count; n++)
      send_item(next_random_item());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_domain(1'b0);

    // Empty table: every lookup falls back to invalid.
    send_fields(ACT_G2M,     32'h0,          INVALID_FRAME, '1);
    send_fields(ACT_M2G,     INVALID_FRAME,  32'h0,         '0);
    send_fields(ACT_M2LOCAL, 32'h0,          32'h1234,      21'd1);
    // Basic insert and lookups in both directions, including the end frame.
    send_fields(ACT_SET,     32'h1000,       32'h8000,      21'd16);
    send_fields(ACT_G2M,     32'h1005,       32'h0,         21'd1);
    send_fields(ACT_M2G,     32'h0,          32'h800F,      21'd1);
    send_fields(ACT_M2G,     32'h0,          32'h8010,      21'd1);
    // Conflicting set on a mapped frame, then a duplicate machine start.
    send_fields(ACT_SET,     32'h1000,       32'h9000,      21'd16);
    send_fields(ACT_SET,     32'h2000,       32'h8000,      21'd4);
    // A zero-length range matches nothing but still blocks its start frame.
    send_fields(ACT_SET,     32'h4000,       32'h5000,      '0);
    send_fields(ACT_G2M,     32'h4000,       32'h0,         21'd1);
    send_fields(ACT_SET,     32'h4000,       32'h6000,      21'd8);
    // Oversize count near the top of the frame space is clipped.
    send_fields(ACT_SET,     32'hFFFF_FFF0,  32'h100,       '1);
    send_fields(ACT_G2M,     32'hFFFF_FFFF,  32'h0,         21'd1);
    // Translations that wrap past the top machine frame.
    send_fields(ACT_SET,     32'd100,        32'hFFFF_FFFE, 21'd4);
    send_fields(ACT_G2M,     32'd101,        32'h0,         21'd1);
    send_fields(ACT_G2M,     32'd102,        32'h0,         21'd1);
    send_fields(ACT_M2G,     32'h0,          32'hFFFF_FFFF, MAX_COUNT);
    // Overlapping guest ranges: the lower entry wins until it is removed.
    send_fields(ACT_SET,     32'h0FF0,       32'hA000,      21'h40);
    send_fields(ACT_G2M,     32'h1005,       32'h0,         21'd1);
    send_fields(ACT_SET,     32'h1003,       INVALID_FRAME, 21'd1);
    send_fields(ACT_G2M,     32'h1005,       32'h0,         21'd1);
    // Remove of an unmapped frame, and a remove that names its own frame.
    send_fields(ACT_SET,     32'h777,        INVALID_FRAME, 21'd1);
    send_fields(ACT_SET,     32'h0FF0,       32'h0FF0,      21'd1);
    send_fields(ACT_M2LOCAL, 32'h0,          32'h100,       21'd1);
    drain();

    // Initial domain: unmapped frames translate to themselves.
    write_domain(1'b1);
    send_fields(ACT_G2M,     32'h12345,      32'h0,         21'd1);
    send_fields(ACT_M2G,     32'h0,          32'h54321,     21'd1);
    send_fields(ACT_M2LOCAL, 32'h0,          32'h9999,      21'd1);
    send_fields(ACT_M2LOCAL, 32'h0,          32'h105,       21'd1);
    send_fields(ACT_M2LOCAL, 32'h0,          32'hFFFF_FFFF, 21'd1);

    // Random phases under both register settings; one without any idling.
    run_random(PHASE_ITEMS);
    drain();
    write_domain(1'b0);
    idle_on <= 1'b0;
    run_random(PHASE_ITEMS);
    drain();
    write_domain(1'b1);
    idle_on <= 1'b1;
    run_random(PHASE_ITEMS);
    drain();
    write_domain(1'b0);
    run_random(PHASE_ITEMS);
    drain();

    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/rftt_pkg.sv
hw/rtl/rftt_ram.sv
hw/rtl/range_frame_translation_table_unit.sv
dv/rftt_translation_checker.sv
dv/tb_top.sv
